/* rtl/core/xfd_pkg.sv */
// ----------------------------------------------------------------------------
// xfd_pkg
// Shared types and constants for the two-channel crossfade controller.
// ----------------------------------------------------------------------------
package xfd_pkg;

    localparam int LEVEL_W = 12;
    localparam int STEP_W  = 12;
    localparam int TRACK_W = 16;

    // full scale: 100 % in 1/30 steps
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(3000);

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PLAY  = 2'd1,
        OP_STOP  = 2'd2,
        OP_LIMIT = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_IN   = 2'd1,
        MODE_OUT  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        START_NONE = 2'd0,
        START_A    = 2'd1,
        START_B    = 2'd2
    } t_start;

    // ramp step result for one channel
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               done;
    } t_ramp;

endpackage

/* rtl/core/xfd_chan_ramp.sv */
// ----------------------------------------------------------------------------
// xfd_chan_ramp
// One channel's level ramp for a tick: up to the limit, down to zero, or hold.
// ----------------------------------------------------------------------------
module xfd_chan_ramp
    import xfd_pkg::*;
(
    input  logic [LEVEL_W-1:0] i_level,
    input  t_mode              i_mode,
    input  logic [STEP_W-1:0]  i_steps,
    input  logic [LEVEL_W-1:0] i_limit,
    output t_ramp              o_ramp
);

    logic [LEVEL_W:0] sum;

    assign sum = {1'b0, i_level} + {1'b0, i_steps};

    always_comb begin
        case (i_mode)
            MODE_IN: begin
                o_ramp.level = (sum > {1'b0, i_limit}) ? i_limit : sum[LEVEL_W-1:0];
                o_ramp.done  = (o_ramp.level == i_limit);
            end
            MODE_OUT: begin
                o_ramp.level = (i_level > i_steps) ? (i_level - i_steps) : '0;
                o_ramp.done  = (o_ramp.level == '0);
            end
            default: begin
                // idle: hold, capped at the limit
                o_ramp.level = (i_level > i_limit) ? i_limit : i_level;
                o_ramp.done  = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/core/two_channel_crossfade_control_top.sv */
// ----------------------------------------------------------------------------
// two_channel_crossfade_control_top
// Crossfade controller for two audio channels with tick, play, stop and
// volume-limit commands; one status beat per command beat.
// ----------------------------------------------------------------------------
// Usage: each accepted input beat is a command (tick, play, stop or limit
// change) and yields exactly one output beat with both channel levels
// (0..3000, 1/30 of a percent point), playing flags, ramp modes, the active
// channel and, for a play, the channel and track to load. The block takes one
// beat per cycle back to back unless the output stalls; a beat passes the
// input register, then the channel state and the result register update
// together. The output register parts the two sides, so a new beat is taken
// while a finished result waits, and input stall rises only when both the
// input register and a stalled result register are full. Reset (synchronous,
// active low) clears both levels, modes and playing flags and sets the limit
// to full scale.
// ----------------------------------------------------------------------------
module two_channel_crossfade_control_top
    import xfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [STEP_W-1:0]  i_elapsed_ms,
    input  logic [TRACK_W-1:0] i_track_id,
    input  logic [LEVEL_W-1:0] i_new_limit,
    input  logic               i_ended_a,
    input  logic               i_ended_b,
    // status channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [LEVEL_W-1:0] o_level_a,
    output logic [LEVEL_W-1:0] o_level_b,
    output logic               o_playing_a,
    output logic               o_playing_b,
    output logic [1:0]         o_fade_a,
    output logic [1:0]         o_fade_b,
    output logic               o_active_channel,
    output logic [1:0]         o_started_channel,
    output logic [TRACK_W-1:0] o_started_track
);

    // ---------------- handshake ----------------
    logic r_in_vld;
    logic r_out_vld;
    logic out_free;   // result register can take a beat this cycle
    logic fire;       // input register beat is processed this cycle
    logic in_take;

    assign out_free = !r_out_vld || !i_stall;
    assign fire     = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign in_take  = i_valid && !o_stall;

    // ---------------- input register ----------------
    t_op                r_op;
    logic [STEP_W-1:0]  r_elapsed;
    logic [TRACK_W-1:0] r_track;
    logic [LEVEL_W-1:0] r_new_limit;
    logic               r_ended_a;
    logic               r_ended_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op        <= t_op'(i_op);
            r_elapsed   <= i_elapsed_ms;
            r_track     <= i_track_id;
            r_new_limit <= i_new_limit;
            r_ended_a   <= i_ended_a;
            r_ended_b   <= i_ended_b;
        end
    end

    // ---------------- channel state ----------------
    logic [LEVEL_W-1:0] r_vol_a, r_vol_b, n_vol_a, n_vol_b;
    t_mode              r_mode_a, r_mode_b, n_mode_a, n_mode_b;
    logic               r_play_a, r_play_b, n_play_a, n_play_b;
    logic [LEVEL_W-1:0] r_limit, n_limit;

    t_ramp              ramp_a, ramp_b;
    logic [LEVEL_W-1:0] lim_sat;
    logic               on_a;
    t_start             n_started;
    logic [TRACK_W-1:0] n_started_trk;
    logic               n_active;
    logic               in_a, in_b;

    xfd_chan_ramp u_ramp_a (
        .i_level (r_vol_a),
        .i_mode  (r_mode_a),
        .i_steps (r_elapsed),
        .i_limit (r_limit),
        .o_ramp  (ramp_a)
    );

    xfd_chan_ramp u_ramp_b (
        .i_level (r_vol_b),
        .i_mode  (r_mode_b),
        .i_steps (r_elapsed),
        .i_limit (r_limit),
        .o_ramp  (ramp_b)
    );

    // limit above full scale saturates
    assign lim_sat = (r_new_limit > FULL_LEVEL) ? FULL_LEVEL : r_new_limit;

    // play target: a free channel first, else the quieter one (tie to B)
    assign on_a = !r_play_a || (r_play_b && (r_vol_a < r_vol_b));

    always_comb begin
        n_vol_a       = r_vol_a;
        n_vol_b       = r_vol_b;
        n_mode_a      = r_mode_a;
        n_mode_b      = r_mode_b;
        n_play_a      = r_play_a;
        n_play_b      = r_play_b;
        n_limit       = r_limit;
        n_started     = START_NONE;
        n_started_trk = '0;
        case (r_op)
            OP_TICK: begin
                // end-of-track flags apply before the ramp
                if (r_ended_a) n_play_a = 1'b0;
                if (r_ended_b) n_play_b = 1'b0;
                n_vol_a = ramp_a.level;
                n_vol_b = ramp_b.level;
                if (ramp_a.done && ramp_b.done) begin
                    if (r_mode_a == MODE_OUT) n_play_a = 1'b0;
                    if (r_mode_b == MODE_OUT) n_play_b = 1'b0;
                    n_mode_a = MODE_IDLE;
                    n_mode_b = MODE_IDLE;
                end
            end
            OP_PLAY: begin
                if (on_a) begin
                    n_vol_a   = '0;
                    n_play_a  = 1'b1;
                    n_mode_a  = MODE_IN;
                    n_mode_b  = MODE_OUT;
                    n_started = START_A;
                end else begin
                    n_vol_b   = '0;
                    n_play_b  = 1'b1;
                    n_mode_b  = MODE_IN;
                    n_mode_a  = MODE_OUT;
                    n_started = START_B;
                end
                n_started_trk = r_track;
            end
            OP_STOP: begin
                if (r_play_a) n_mode_a = MODE_OUT;
                if (r_play_b) n_mode_b = MODE_OUT;
            end
            default: begin
                // limit change: cap levels, idle channels start a fade-in
                n_limit = lim_sat;
                if (r_vol_a > lim_sat) n_vol_a = lim_sat;
                if (r_vol_b > lim_sat) n_vol_b = lim_sat;
                if (r_mode_a == MODE_IDLE) n_mode_a = MODE_IN;
                if (r_mode_b == MODE_IDLE) n_mode_b = MODE_IN;
            end
        endcase
    end

    // active channel from the state after the beat
    assign in_a = (n_mode_a == MODE_IN);
    assign in_b = (n_mode_b == MODE_IN);

    always_comb begin
        if (n_play_a && n_play_b) begin
            if (in_a && in_b) begin
                n_active = !(n_vol_a > n_vol_b);
            end else begin
                n_active = !in_a && in_b;
            end
        end else begin
            // only B playing selects B; none or only A selects A
            n_active = !n_play_a && n_play_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_a  <= '0;
            r_vol_b  <= '0;
            r_mode_a <= MODE_IDLE;
            r_mode_b <= MODE_IDLE;
            r_play_a <= 1'b0;
            r_play_b <= 1'b0;
            r_limit  <= FULL_LEVEL;
        end else if (fire) begin
            r_vol_a  <= n_vol_a;
            r_vol_b  <= n_vol_b;
            r_mode_a <= n_mode_a;
            r_mode_b <= n_mode_b;
            r_play_a <= n_play_a;
            r_play_b <= n_play_b;
            r_limit  <= n_limit;
        end
    end

    // ---------------- result register ----------------
    logic               r_active;
    t_start             r_started;
    logic [TRACK_W-1:0] r_started_trk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_active      <= n_active;
            r_started     <= n_started;
            r_started_trk <= n_started_trk;
        end
    end

    // channel state registers double as the level/flag/mode outputs:
    // they change only when a new result is loaded
    assign o_valid           = r_out_vld;
    assign o_level_a         = r_vol_a;
    assign o_level_b         = r_vol_b;
    assign o_playing_a       = r_play_a;
    assign o_playing_b       = r_play_b;
    assign o_fade_a          = r_mode_a;
    assign o_fade_b          = r_mode_b;
    assign o_active_channel  = r_active;
    assign o_started_channel = r_started;
    assign o_started_track   = r_started_trk;

    // ---------------- assertions ----------------
    a_level_a_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vol_a <= r_limit)
        else $error("level A above volume limit");

    a_level_b_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vol_b <= r_limit)
        else $error("level B above volume limit");

    a_limit_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_limit <= FULL_LEVEL)
        else $error("volume limit above full scale");

    a_start_a_fades_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_started == START_A) |->
            (r_play_a && r_mode_a == MODE_IN && r_mode_b == MODE_OUT))
        else $error("started channel A not fading in");

    a_start_b_fades_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_started == START_B) |->
            (r_play_b && r_mode_b == MODE_IN && r_mode_a == MODE_OUT))
        else $error("started channel B not fading in");

    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_vld && r_out_vld && i_stall))
        else $error("input stalled without a held beat");

endmodule
